// ===== sv/cbi_pkg.sv =====
// shared types and codes for the cbor item encoder
`default_nettype none

package cbi_pkg;

    // item kinds on the input tuser
    localparam logic [3:0] KIND_UINT     = 4'd0;
    localparam logic [3:0] KIND_SINT     = 4'd1;
    localparam logic [3:0] KIND_FLOAT64  = 4'd2;
    localparam logic [3:0] KIND_BOOL     = 4'd3;
    localparam logic [3:0] KIND_NULL     = 4'd4;
    localparam logic [3:0] KIND_TEXT_HDR = 4'd5;
    localparam logic [3:0] KIND_TEXT_BYTE = 4'd6;
    localparam logic [3:0] KIND_MAP      = 4'd7;
    localparam logic [3:0] KIND_ARRAY    = 4'd8;

    // cbor major types
    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_NINT  = 3'd1;
    localparam logic [2:0] MT_TEXT  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP   = 3'd5;

    localparam logic [7:0] BYTE_FALSE   = 8'hF4;
    localparam logic [7:0] BYTE_TRUE    = 8'hF5;
    localparam logic [7:0] BYTE_NULL    = 8'hF6;
    localparam logic [7:0] BYTE_FLOAT64 = 8'hFB;

    localparam int unsigned POS_W = 32;
    localparam int unsigned LEN_W = 4;

    // one encoded item: first byte plus up to eight more, left aligned
    typedef struct packed {
        logic             ok;
        logic [7:0]       head;
        logic [63:0]      tail;
        logic [LEN_W-1:0] len;
    } enc_t;

endpackage

`default_nettype wire

// ===== sv/cbi_head_enc.sv =====
// combinational encoder of one item into its cbor bytes
`default_nettype none

module cbi_head_enc
    import cbi_pkg::*;
(
    input  wire logic [3:0]  kind,
    input  wire logic [63:0] value,
    output enc_t             enc
);

    function automatic enc_t head_form(input logic [2:0] major, input logic [63:0] arg);
        enc_t e;
        e.ok   = 1'b1;
        e.tail = '0;
        if (arg <= 64'd23)
        begin
            e.head = {major, arg[4:0]};
            e.len  = LEN_W'(1);
        end
        else if (arg <= 64'hFF)
        begin
            e.head = {major, 5'd24};
            e.tail = {arg[7:0], 56'd0};
            e.len  = LEN_W'(2);
        end
        else if (arg <= 64'hFFFF)
        begin
            e.head = {major, 5'd25};
            e.tail = {arg[15:0], 48'd0};
            e.len  = LEN_W'(3);
        end
        else if (arg <= 64'hFFFF_FFFF)
        begin
            e.head = {major, 5'd26};
            e.tail = {arg[31:0], 32'd0};
            e.len  = LEN_W'(5);
        end
        else
        begin
            e.head = {major, 5'd27};
            e.tail = arg;
            e.len  = LEN_W'(9);
        end
        return e;
    endfunction

    always_comb
    begin
        enc = '0;
        unique case (kind)
            KIND_UINT:      enc = head_form(MT_UINT, value);
            KIND_SINT:
            begin
                if (value[63])
                    enc = head_form(MT_NINT, ~value);
                else
                    enc = head_form(MT_UINT, value);
            end
            KIND_FLOAT64:
            begin
                enc.ok   = 1'b1;
                enc.head = BYTE_FLOAT64;
                enc.tail = value;
                enc.len  = LEN_W'(9);
            end
            KIND_BOOL:
            begin
                enc.ok   = 1'b1;
                enc.head = (|value) ? BYTE_TRUE : BYTE_FALSE;
                enc.len  = LEN_W'(1);
            end
            KIND_NULL:
            begin
                enc.ok   = 1'b1;
                enc.head = BYTE_NULL;
                enc.len  = LEN_W'(1);
            end
            KIND_TEXT_HDR:  enc = head_form(MT_TEXT, value);
            KIND_TEXT_BYTE:
            begin
                enc.ok   = 1'b1;
                enc.head = value[7:0];
                enc.len  = LEN_W'(1);
            end
            KIND_MAP:       enc = head_form(MT_MAP, value);
            KIND_ARRAY:     enc = head_form(MT_ARRAY, value);
            default:        enc = '0;   // unused kinds are dropped
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/cbor_item_encoder.sv =====
// top level of the cbor item encoder: input register, encoder and byte emitter
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tuser = kind, tdata = value
// m_axis    out  m_axis_tvalid/tready       tdata = out_byte, position; tuser = overflow;
//                                           tlast = last byte of the item
// cfg       in   cfg_wen                    cfg_wdata = capacity
//
// one output byte per cycle unless the output stalls; an item holds the input until
// its last byte is loaded, so single-byte items (text bytes, bool, null, small ints)
// flow at one per cycle; the rate is set by the single output register and 8-byte shift buffer
// reset clears the write position to zero and sets capacity to all ones
// a stalled output holds its transaction; the input register still takes one item
// an overflowing item gives a single transaction and writes nothing
`default_nettype none

module cbor_item_encoder
    import cbi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // value[63:0]
    input  wire logic [3:0]  s_axis_tuser,   // kind[3:0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // out_byte[7:0], position[39:8]
    output logic             m_axis_tuser,   // overflow[0]
    output logic             m_axis_tlast,

    input  wire logic        cfg_wen,
    input  wire logic [31:0] cfg_wdata       // capacity
);

    // input register
    logic              in_valid_reg;
    logic [3:0]        in_kind_reg;
    logic [63:0]       in_value_reg;

    // capacity and running byte count
    logic [POS_W-1:0]  cap_reg;
    logic [POS_W-1:0]  wpos_reg;

    // output register
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;
    logic [POS_W-1:0]  out_pos_reg;

    // bytes still to go for the item in flight, top byte first
    logic [63:0]       rem_reg;
    logic [LEN_W-1:0]  rem_cnt_reg;
    logic [POS_W-1:0]  next_pos_reg;

    enc_t              enc;
    logic              out_adv;
    logic              in_take;
    logic              fits;
    logic [POS_W:0]    end_pos;

    cbi_head_enc u_enc
    (
        .kind  (in_kind_reg),
        .value (in_value_reg),
        .enc   (enc)
    );

    // the item fits when the position after it stays within capacity
    assign end_pos = {1'b0, wpos_reg} + (POS_W+1)'(enc.len);
    assign fits    = end_pos <= {1'b0, cap_reg};

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign in_take       = out_adv && (rem_cnt_reg == '0) && in_valid_reg;
    assign s_axis_tready = !in_valid_reg || in_take;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pos_reg, out_byte_reg};
    assign m_axis_tuser  = out_ovf_reg;
    assign m_axis_tlast  = out_last_reg;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= '1;
        else if (cfg_wen)
            cap_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg  <= s_axis_tuser;
            in_value_reg <= s_axis_tdata;
        end
    end

    // emitter control: valid, remaining count, write position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_cnt_reg   <= '0;
            wpos_reg      <= '0;
        end
        else if (out_adv)
        begin
            priority if (rem_cnt_reg != '0)
            begin
                out_valid_reg <= 1'b1;
                rem_cnt_reg   <= rem_cnt_reg - LEN_W'(1);
            end
            else if (in_valid_reg && enc.ok)
            begin
                out_valid_reg <= 1'b1;
                if (fits)
                begin
                    rem_cnt_reg <= enc.len - LEN_W'(1);
                    wpos_reg    <= end_pos[POS_W-1:0];
                end
            end
            else
            begin
                out_valid_reg <= 1'b0;  // unused kind or nothing waiting
            end
        end
    end

    // emitter payload
    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            priority if (rem_cnt_reg != '0)
            begin
                out_byte_reg <= rem_reg[63:56];
                out_last_reg <= (rem_cnt_reg == LEN_W'(1));
                out_ovf_reg  <= 1'b0;
                out_pos_reg  <= next_pos_reg;
                rem_reg      <= {rem_reg[55:0], 8'd0};
                next_pos_reg <= next_pos_reg + POS_W'(1);
            end
            else if (in_valid_reg && fits)
            begin
                out_byte_reg <= enc.head;
                out_last_reg <= (enc.len == LEN_W'(1));
                out_ovf_reg  <= 1'b0;
                out_pos_reg  <= wpos_reg + POS_W'(1);
                rem_reg      <= enc.tail;
                next_pos_reg <= wpos_reg + POS_W'(2);
            end
            else
            begin
                // overflow transaction: zero byte, position unchanged
                out_byte_reg <= 8'd0;
                out_last_reg <= 1'b1;
                out_ovf_reg  <= 1'b1;
                out_pos_reg  <= wpos_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking bench for the cbor item encoder, with a byte-level scoreboard
import cbi_pkg::*;

typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        ovf;
    logic [31:0] pos;
} cbor_byte_t;

class cbor_byte_board;
    localparam logic [4:0] AI_DIRECT_MAX = 5'd23;
    localparam logic [4:0] AI_UINT8      = 5'd24;
    localparam logic [4:0] AI_UINT16     = 5'd25;
    localparam logic [4:0] AI_UINT32     = 5'd26;
    localparam logic [4:0] AI_UINT64     = 5'd27;
    localparam int         MAX_PRINTED   = 40;

    logic [31:0] capacity;
    logic [31:0] write_pos;
    logic [7:0]  enc_buf [9];
    cbor_byte_t  expected_bytes [$];
    int          err_count;
    int          items_noted;
    int          bytes_checked;
    int          overflows_seen;

    function new();
        capacity       = 32'hFFFF_FFFF;
        write_pos      = 32'd0;
        err_count      = 0;
        items_noted    = 0;
        bytes_checked  = 0;
        overflows_seen = 0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    task report(string what);
        err_count++;
        // keep the log short on a badly broken block
        if (err_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // shortest-form head into enc_buf, returns its length
    function int build_head(logic [2:0] major, logic [63:0] arg);
        int n;
        int i;
        logic [4:0] ai;
        if (arg <= 64'(AI_DIRECT_MAX))
        begin
            enc_buf[0] = {major, arg[4:0]};
            return 1;
        end
        if (arg <= 64'hFF)
        begin
            ai = AI_UINT8;
            n  = 1;
        end
        else if (arg <= 64'hFFFF)
        begin
            ai = AI_UINT16;
            n  = 2;
        end
        else if (arg <= 64'hFFFF_FFFF)
        begin
            ai = AI_UINT32;
            n  = 4;
        end
        else
        begin
            ai = AI_UINT64;
            n  = 8;
        end
        enc_buf[0] = {major, ai};
        for (i = 0; i < n; i++)
            enc_buf[1 + i] = 8'(arg >> (8 * (n - 1 - i)));
        return n + 1;
    endfunction

    // encode one accepted item and queue the bytes it should produce
    function void encode_item(logic [3:0] kind, logic [63:0] value);
        int len;
        int i;
        cbor_byte_t b;
        case (kind)
            KIND_UINT:      len = build_head(MT_UINT, value);
            KIND_SINT:      len = value[63] ? build_head(MT_NINT, ~value)
                                            : build_head(MT_UINT, value);
            KIND_FLOAT64:
            begin
                enc_buf[0] = BYTE_FLOAT64;
                for (i = 0; i < 8; i++)
                    enc_buf[1 + i] = 8'(value >> (8 * (7 - i)));
                len = 9;
            end
            KIND_BOOL:
            begin
                enc_buf[0] = (value != 64'd0) ? BYTE_TRUE : BYTE_FALSE;
                len = 1;
            end
            KIND_NULL:
            begin
                enc_buf[0] = BYTE_NULL;
                len = 1;
            end
            KIND_TEXT_HDR:  len = build_head(MT_TEXT, value);
            KIND_TEXT_BYTE:
            begin
                enc_buf[0] = value[7:0];
                len = 1;
            end
            KIND_MAP:       len = build_head(MT_MAP, value);
            KIND_ARRAY:     len = build_head(MT_ARRAY, value);
            default:        return;
        endcase
        items_noted++;
        if ({1'b0, write_pos} + 33'(len) > {1'b0, capacity})
        begin
            b = '{data: 8'd0, last: 1'b1, ovf: 1'b1, pos: write_pos};
            expected_bytes.push_back(b);
            return;
        end
        for (i = 0; i < len; i++)
        begin
            write_pos = write_pos + 32'd1;
            b = '{data: enc_buf[i], last: (i == len - 1), ovf: 1'b0, pos: write_pos};
            expected_bytes.push_back(b);
        end
    endfunction

    task check_result(logic [7:0] data, logic last, logic ovf, logic [31:0] pos);
        cbor_byte_t e;
        if (expected_bytes.size() == 0)
        begin
            report($sformatf("unexpected byte %02h last %0b ovf %0b pos %0d",
                             data, last, ovf, pos));
            return;
        end
        e = expected_bytes.pop_front();
        bytes_checked++;
        if (ovf)
            overflows_seen++;
        if (data !== e.data)
            report($sformatf("byte %02h, expected %02h", data, e.data));
        if (last !== e.last)
            report($sformatf("last %0b, expected %0b", last, e.last));
        if (ovf !== e.ovf)
            report($sformatf("overflow %0b, expected %0b", ovf, e.ovf));
        if (pos !== e.pos)
            report($sformatf("position %0d, expected %0d", pos, e.pos));
    endtask
endclass

module tb;
    localparam int         HALF_PERIOD    = 6;
    localparam int         RESET_CYCLES   = 7;
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         MAX_GAP        = 40;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
    localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wen;
    logic [31:0] cfg_wdata;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;

    cbor_byte_board board = new();

    cbor_item_encoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // output side: random back-pressure, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // every output transaction goes to the scoreboard
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata[7:0], m_axis_tlast, m_axis_tuser,
                                   m_axis_tdata[39:8]);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a transaction", quiet);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_item(input logic [3:0] kind, input logic [63:0] value);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.encode_item(kind, value);
    endtask

    // stop offering, wait for every expected byte, then let the pipe empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [31:0] cap);
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        board.capacity = cap;
    endtask

    function automatic logic [63:0] arg_of_size();
        case ($urandom_range(0, 5))
            0:       return 64'($urandom_range(0, 23));
            1:       return 64'($urandom_range(24, 255));
            2:       return 64'($urandom_range(256, 65535));
            3:       return 64'($urandom_range(65536, 32'hFFFF_FFFF));
            4:       return {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [63:0] pick_value(input logic [3:0] kind);
        logic [63:0] v;
        case (kind)
            KIND_UINT, KIND_TEXT_HDR, KIND_MAP, KIND_ARRAY:
                v = arg_of_size();
            KIND_SINT:
            begin
                v = arg_of_size();
                if ($urandom_range(0, 1))
                    v = ~v;
            end
            KIND_BOOL:
                v = $urandom_range(0, 1) ? 64'($urandom_range(0, 1))
                                         : {32'($urandom), 32'($urandom)};
            default:
                v = {32'($urandom), 32'($urandom)};
        endcase
        return v;
    endfunction

    // unused kinds are sent now and then but not counted
    task automatic send_random(input int count);
        int sent;
        logic [3:0] kind;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 4)
                kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            else
                kind = 4'($urandom_range(KIND_UINT, KIND_ARRAY));
            send_item(kind, pick_value(kind));
            if (kind <= KIND_ARRAY)
                sent++;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 64'd0;
        s_axis_tuser   = KIND_UINT;
        cfg_wen        = 1'b0;
        cfg_wdata      = 32'd0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // head size boundaries, both integer signs, every kind, reset capacity
        send_item(KIND_UINT, 64'd0);
        send_item(KIND_UINT, 64'd23);
        send_item(KIND_UINT, 64'd24);
        send_item(KIND_UINT, 64'd255);
        send_item(KIND_UINT, 64'd256);
        send_item(KIND_UINT, 64'h1_0000);
        send_item(KIND_UINT, 64'hFFFF_FFFF);
        send_item(KIND_UINT, 64'h1_0000_0000);
        send_item(KIND_UINT, '1);
        send_item(KIND_SINT, '1);
        send_item(KIND_SINT, 64'hFFFF_FFFF_FFFF_FFE8);
        send_item(KIND_SINT, 64'hFFFF_FFFF_FFFF_FFE7);
        send_item(KIND_SINT, 64'h8000_0000_0000_0000);
        send_item(KIND_SINT, 64'd100);
        send_item(KIND_FLOAT64, 64'h0123_4567_89AB_CDEF);
        send_item(KIND_BOOL, 64'd0);
        // a nonzero value with only high bits set is still true
        send_item(KIND_BOOL, 64'h100);
        send_item(KIND_NULL, 64'd0);
        send_item(KIND_TEXT_HDR, 64'd5);
        send_item(KIND_TEXT_HDR, 64'd300);
        // only the low byte of a text byte counts
        send_item(KIND_TEXT_BYTE, 64'hFFFF_FFFF_FFFF_FF41);
        send_item(KIND_MAP, 64'd24);
        send_item(KIND_ARRAY, 64'h1_0000);
        send_item(KIND_UNUSED_LO, '1);
        send_item(KIND_UNUSED_HI, 64'd0);

        // sender mostly idle
        src_idle_pct = 80;
        send_random(110);

        // long output hold-off while the input keeps offering, then a full pause
        src_idle_pct = 0;
        hold_left    = HOLD_CYCLES;
        send_random(40);
        drain();

        // exact fit of a nine-byte item, then nothing more fits
        write_capacity(board.write_pos + 32'd9);
        send_item(KIND_FLOAT64, {32'($urandom), 32'($urandom)});
        send_item(KIND_UINT, 64'd0);
        send_item(KIND_TEXT_BYTE, 64'h5A);
        drain();

        // a little room left, receiver mostly stalling
        write_capacity(board.write_pos + 32'd40);
        sink_stall_pct = 80;
        send_random(60);
        drain();

        // zero capacity, both sides idle now and then
        write_capacity(32'd0);
        src_idle_pct   = 8;
        sink_stall_pct = 8;
        send_random(30);
        drain();

        // capacity below the bytes already written
        write_capacity(board.write_pos >> 1);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_random(30);
        drain();

        // back to full capacity
        write_capacity(32'hFFFF_FFFF);
        src_idle_pct   = 8;
        sink_stall_pct = 8;
        send_random(120);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_random(40);
        drain();

        if (board.pending() != 0)
            board.report($sformatf("%0d expected bytes never arrived", board.pending()));
        $display("%0d items encoded, %0d output transactions checked, %0d overflows",
                 board.items_noted, board.bytes_checked, board.overflows_seen);
        $display("capacity full, exact, tight, zero and below position; idle and stall mixes");
        if (board.err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
